// File: src/tsq_pkg.sv
package tsq_pkg;

  localparam int DEF_CAPACITY  = 1024;
  localparam int DEF_NUM_TYPES = 3;
  localparam int ENTRY_SLOTS   = 3;
  localparam int QDEPTH        = 2;
  localparam logic [10:0] TOTAL_LIMIT_RST = 11'd1024;

  typedef enum logic [1:0] {
    ST_STORED      = 2'd0,
    ST_REFUSED     = 2'd1,
    ST_DELIVERED   = 2'd2,
    ST_UNAVAILABLE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_TOTAL_LIMIT  = 3'd0,
    REG_TYPES_IN_USE = 3'd1,
    REG_TYPE_ID_0    = 3'd2,
    REG_TYPE_ID_1    = 3'd3,
    REG_TYPE_ID_2    = 3'd4,
    REG_QUOTA_0      = 3'd5,
    REG_QUOTA_1      = 3'd6,
    REG_QUOTA_2      = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN
  } bk_state_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        kind;
    logic [23:0] item_type;
    logic [23:0] producer;
    logic [31:0] number;
    logic        hit;
    logic [1:0]  entry;
    logic        refuse;
  } cmd_t;

  // one stored slot
  typedef struct packed {
    logic        valid;
    logic [23:0] stype;
    logic [23:0] prod;
    logic [31:0] num;
    logic [31:0] age;
  } slot_t;

  // back status seen by the front
  typedef struct packed {
    logic                        idle;
    logic [ENTRY_SLOTS-1:0][10:0] counts;
  } bk_stat_t;

endpackage

// File: src/tsq_queue.sv
module tsq_queue
  import tsq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t       mem_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign empty    = (count_r == 2'd0);
  assign do_push  = push && (count_r != 2'(QDEPTH));
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/tsq_front.sv
module tsq_front
  import tsq_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int NUM_TYPES = DEF_NUM_TYPES,
  localparam int OW = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic          in_kind,
  input  logic [23:0]   in_item_type,
  input  logic [23:0]   in_producer_name,
  input  logic [31:0]   in_item_number,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [23:0]   cfg_data,
  input  logic          q_empty,
  input  bk_stat_t      stat,
  input  logic [OW-1:0] occ,
  output logic          push,
  output cmd_t          cmd
);

  logic [10:0] total_limit_r;
  logic [1:0]  types_in_use_r;
  logic [23:0] type_id_r [ENTRY_SLOTS];
  logic [10:0] quota_r   [ENTRY_SLOTS];

  logic [1:0]  active;
  logic        hit;
  logic [1:0]  entry;
  logic [31:0] occ_w, lim_w;
  logic        over_quota;

  assign cfg_ready = 1'b1;
  assign busy      = !q_empty || !stat.idle;
  assign push      = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_limit_r  <= TOTAL_LIMIT_RST;
      types_in_use_r <= 2'd0;
      for (int i = 0; i < ENTRY_SLOTS; i++) begin
        type_id_r[i] <= 24'd0;
        quota_r[i]   <= 11'd0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_TOTAL_LIMIT:  total_limit_r  <= cfg_data[10:0];
        REG_TYPES_IN_USE: types_in_use_r <= cfg_data[1:0];
        REG_TYPE_ID_0:    type_id_r[0]   <= cfg_data;
        REG_TYPE_ID_1:    type_id_r[1]   <= cfg_data;
        REG_TYPE_ID_2:    type_id_r[2]   <= cfg_data;
        REG_QUOTA_0:      quota_r[0]     <= cfg_data[10:0];
        REG_QUOTA_1:      quota_r[1]     <= cfg_data[10:0];
        REG_QUOTA_2:      quota_r[2]     <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // highest matching active entry wins
  always_comb begin
    active = (types_in_use_r > 2'(NUM_TYPES)) ? 2'(NUM_TYPES) : types_in_use_r;
    hit    = 1'b0;
    entry  = 2'd0;
    for (int i = 0; i < ENTRY_SLOTS; i++) begin
      if ((2'(i) < active) && (type_id_r[i] == in_item_type)) begin
        hit   = 1'b1;
        entry = 2'(i);
      end
    end
  end

  always_comb begin
    occ_w = 32'(occ);
    lim_w = (32'(total_limit_r) > 32'(CAPACITY)) ? 32'(CAPACITY) : 32'(total_limit_r);
    over_quota = hit && (stat.counts[entry] >= quota_r[entry]);
    cmd.kind      = in_kind;
    cmd.item_type = in_item_type;
    cmd.producer  = in_producer_name;
    cmd.number    = in_item_number;
    cmd.hit       = hit;
    cmd.entry     = entry;
    cmd.refuse    = !in_kind && ((occ_w >= lim_w) || over_quota);
  end

endmodule

// File: src/tsq_back.sv
module tsq_back
  import tsq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int OW = $clog2(CAPACITY + 1),
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  cmd_t          q_data,
  output logic          pop,
  output bk_stat_t      stat,
  output logic [OW-1:0] occ,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic [23:0]   out_type,
  output logic [23:0]   out_producer,
  output logic [31:0]   out_number
);

  localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

  slot_t mem [CAPACITY];

  bk_state_t state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          done_issue_r, done_issue_nxt;
  logic          chk_v_r;
  logic [IW-1:0] chk_idx_r;
  slot_t         rdata_r;
  cmd_t          cmd_r, cmd_nxt;
  logic          have_r, have_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [31:0]   best_el_r, best_el_nxt;
  slot_t         best_r, best_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [ENTRY_SLOTS-1:0][10:0] counts_r, counts_nxt;
  logic [31:0]   stamp_r, stamp_nxt;
  logic          ov_r, ov_nxt;
  logic [1:0]    os_r, os_nxt;
  logic [23:0]   ot_r, ot_nxt;
  logic [23:0]   op_r, op_nxt;
  logic [31:0]   on_r, on_nxt;

  logic          we;
  logic [IW-1:0] waddr;
  slot_t         wdata;

  logic          match, take, have_f, last, free;
  logic [31:0]   el;
  logic [IW-1:0] bidx_f;
  slot_t         bdat_f;

  assign stat.idle   = (state_r == BK_IDLE);
  assign stat.counts = counts_r;
  assign occ          = occ_r;
  assign out_valid    = ov_r;
  assign out_status   = os_r;
  assign out_type     = ot_r;
  assign out_producer = op_r;
  assign out_number   = on_r;

  always_comb begin
    match  = chk_v_r && rdata_r.valid && (rdata_r.stype == cmd_r.item_type);
    el     = stamp_r - rdata_r.age;
    take   = match && (!have_r || (el > best_el_r));
    have_f = have_r || take;
    bidx_f = take ? chk_idx_r : best_idx_r;
    bdat_f = take ? rdata_r : best_r;
    last   = chk_v_r && (chk_idx_r == LAST);
    free   = chk_v_r && !rdata_r.valid;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    done_issue_nxt = done_issue_r;
    cmd_nxt        = cmd_r;
    have_nxt       = have_r;
    best_idx_nxt   = best_idx_r;
    best_el_nxt    = best_el_r;
    best_nxt       = best_r;
    occ_nxt        = occ_r;
    counts_nxt     = counts_r;
    stamp_nxt      = stamp_r;
    ov_nxt         = 1'b0;
    os_nxt         = os_r;
    ot_nxt         = ot_r;
    op_nxt         = op_r;
    on_nxt         = on_r;
    pop            = 1'b0;
    we             = 1'b0;
    waddr          = cnt_r;
    wdata          = '0;
    case (state_r)
      BK_CLEAR: begin
        we = 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = BK_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          cmd_nxt = q_data;
          if (q_data.refuse) begin
            ov_nxt = 1'b1;
            os_nxt = ST_REFUSED;
            ot_nxt = '0;
            op_nxt = '0;
            on_nxt = '0;
          end else begin
            state_nxt      = BK_SCAN;
            cnt_nxt        = '0;
            done_issue_nxt = 1'b0;
            have_nxt       = 1'b0;
          end
        end
      end
      BK_SCAN: begin
        if (!done_issue_r) begin
          if (cnt_r == LAST) begin
            done_issue_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        have_nxt     = have_f;
        best_idx_nxt = bidx_f;
        best_el_nxt  = take ? el : best_el_r;
        best_nxt     = bdat_f;
        if (!cmd_r.kind) begin
          if (free) begin
            we          = 1'b1;
            waddr       = chk_idx_r;
            wdata.valid = 1'b1;
            wdata.stype = cmd_r.item_type;
            wdata.prod  = cmd_r.producer;
            wdata.num   = cmd_r.number;
            wdata.age   = stamp_r;
            stamp_nxt   = stamp_r + 32'd1;
            occ_nxt     = occ_r + 1'b1;
            if (cmd_r.hit) begin
              counts_nxt[cmd_r.entry] = counts_r[cmd_r.entry] + 11'd1;
            end
            ov_nxt    = 1'b1;
            os_nxt    = ST_STORED;
            ot_nxt    = '0;
            op_nxt    = '0;
            on_nxt    = '0;
            state_nxt = BK_IDLE;
          end else if (last) begin
            ov_nxt    = 1'b1;
            os_nxt    = ST_REFUSED;
            ot_nxt    = '0;
            op_nxt    = '0;
            on_nxt    = '0;
            state_nxt = BK_IDLE;
          end
        end else if (last) begin
          ov_nxt    = 1'b1;
          state_nxt = BK_IDLE;
          if (have_f) begin
            we      = 1'b1;
            waddr   = bidx_f;
            wdata   = '0;
            os_nxt  = ST_DELIVERED;
            ot_nxt  = bdat_f.stype;
            op_nxt  = bdat_f.prod;
            on_nxt  = bdat_f.num;
            if (occ_r != '0) begin
              occ_nxt = occ_r - 1'b1;
            end
            if (cmd_r.hit && (counts_r[cmd_r.entry] != 11'd0)) begin
              counts_nxt[cmd_r.entry] = counts_r[cmd_r.entry] - 11'd1;
            end
          end else begin
            os_nxt = ST_UNAVAILABLE;
            ot_nxt = '0;
            op_nxt = '0;
            on_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_CLEAR;
      cnt_r    <= '0;
      chk_v_r  <= 1'b0;
      occ_r    <= '0;
      counts_r <= '0;
      stamp_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      chk_v_r  <= (state_r == BK_SCAN) && !done_issue_r && (state_nxt == BK_SCAN);
      occ_r    <= occ_nxt;
      counts_r <= counts_nxt;
      stamp_r  <= stamp_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    done_issue_r <= done_issue_nxt;
    chk_idx_r    <= cnt_r;
    cmd_r        <= cmd_nxt;
    have_r       <= have_nxt;
    best_idx_r   <= best_idx_nxt;
    best_el_r    <= best_el_nxt;
    best_r       <= best_nxt;
    os_r         <= os_nxt;
    ot_r         <= ot_nxt;
    op_r         <= op_nxt;
    on_r         <= on_nxt;
  end

  // slot store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[cnt_r];
  end

endmodule

// File: src/typed_store_with_quotas.sv
// typed store with per-type quotas
// - command channel: in_kind, in_item_type, in_producer_name, in_item_number
//   are taken at a rising edge with start high and busy low
// - one result per request on out_status, out_type, out_producer, out_number,
//   marked by out_valid for exactly one cycle; the receiver cannot stall
// - config writes on cfg_valid / cfg_ready (always ready), cfg_index picks
//   the register, cfg_data carries the value; write only while busy is low
// - a request refused by limit or quota is popped from the queue and
//   answered without a scan; any other request scans the slot memory one
//   slot a cycle (a produce stops at the first free slot)
// - one request in flight at a time, the slot memory read port sets the pace
// - after reset busy stays high while the slot memory is cleared one
//   entry a cycle; config writes are taken meanwhile
module typed_store_with_quotas
  import tsq_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int NUM_TYPES = DEF_NUM_TYPES,
  localparam int OW = $clog2(CAPACITY + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [23:0] in_item_type,
  input  logic [23:0] in_producer_name,
  input  logic [31:0] in_item_number,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [23:0] out_type,
  output logic [23:0] out_producer,
  output logic [31:0] out_number,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // front to queue
  logic     push;
  cmd_t     push_cmd;
  // queue to back
  logic     pop;
  cmd_t     pop_cmd;
  logic     q_empty;
  // back status fed to the front for classification
  bk_stat_t stat;
  logic [OW-1:0] occ;

  tsq_front #(
    .CAPACITY  (CAPACITY),
    .NUM_TYPES (NUM_TYPES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_item_type     (in_item_type),
    .in_producer_name (in_producer_name),
    .in_item_number   (in_item_number),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_empty          (q_empty),
    .stat             (stat),
    .occ              (occ),
    .push             (push),
    .cmd              (push_cmd)
  );

  // short queue decoupling classification from execution
  tsq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .empty     (q_empty)
  );

  // back end owns the slot memory, counts and the result register
  tsq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (pop_cmd),
    .pop          (pop),
    .stat         (stat),
    .occ          (occ),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_type     (out_type),
    .out_producer (out_producer),
    .out_number   (out_number)
  );

endmodule

// File: src/tsq_checker.sv
module tsq_checker
  import tsq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [23:0] out_type,
  input logic [23:0] out_producer,
  input logic [31:0] out_number
);

  // clearing pass follows every reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request transfer did not raise busy");

  a_no_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in a row");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_DELIVERED)) |->
      (out_type == 24'd0 && out_producer == 24'd0 && out_number == 32'd0))
    else $error("nonzero item fields without delivery");

endmodule

bind typed_store_with_quotas tsq_checker u_tsq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_type     (out_type),
  .out_producer (out_producer),
  .out_number   (out_number)
);

// File: sim/tb_typed_store_with_quotas.sv
`timescale 1ns / 1ps

module tb_typed_store_with_quotas;
  import tsq_pkg::*;

  localparam int CAP      = DEF_CAPACITY;
  localparam int NTYPES   = DEF_NUM_TYPES;
  localparam int SETTLE   = CAP + 40;
  localparam int MAX_CYC  = 4_000_000;

  // a few short type names so consumes actually find matches
  localparam logic [23:0] TY_A = 24'h414141;
  localparam logic [23:0] TY_B = 24'h424242;
  localparam logic [23:0] TY_C = 24'h434343;
  localparam logic [23:0] TY_D = 24'hFFFFFF;

  localparam logic KIND_PRODUCE = 1'b0;
  localparam logic KIND_CONSUME = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_kind;
  logic [23:0] in_item_type;
  logic [23:0] in_producer_name;
  logic [31:0] in_item_number;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [23:0] out_type;
  logic [23:0] out_producer;
  logic [31:0] out_number;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  typed_store_with_quotas i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_item_type    (in_item_type),
    .in_producer_name(in_producer_name),
    .in_item_number  (in_item_number),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_type        (out_type),
    .out_producer    (out_producer),
    .out_number      (out_number),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // one result as seen on the output ports
  typedef struct packed {
    status_t     status;
    logic [23:0] rtype;
    logic [23:0] rprod;
    logic [31:0] rnum;
  } answer_t;

  // one row of the directed table; chk says the typed-in answer is compared
  typedef struct {
    logic    kind;
    logic [23:0] ity;
    logic [23:0] prod;
    logic [31:0] num;
    bit      chk;
    answer_t ans;
  } row_t;

  // ---------------- store model ----------------
  logic [10:0] m_limit;
  logic [1:0]  m_in_use;
  logic [23:0] m_tid [ENTRY_SLOTS];
  logic [10:0] m_quota [ENTRY_SLOTS];
  bit          m_valid [CAP];
  logic [23:0] m_type [CAP];
  logic [23:0] m_prod [CAP];
  logic [31:0] m_num [CAP];
  logic [31:0] m_age [CAP];
  int unsigned m_occ;
  logic [10:0] m_count [ENTRY_SLOTS];
  logic [31:0] m_stamp;

  answer_t pending_answers[$];
  int      n_err;
  int      n_cyc;

  function automatic int entry_of(logic [23:0] t);
    int act, hit;
    act = (m_in_use > NTYPES) ? NTYPES : m_in_use;
    hit = -1;
    for (int i = 0; i < act; i++)
      if (m_tid[i] == t) hit = i;
    return hit;
  endfunction

  task automatic store_write(reg_idx_t idx, logic [23:0] val);
    case (idx)
      REG_TOTAL_LIMIT:  m_limit = val[10:0];
      REG_TYPES_IN_USE: m_in_use = val[1:0];
      REG_TYPE_ID_0:    m_tid[0] = val;
      REG_TYPE_ID_1:    m_tid[1] = val;
      REG_TYPE_ID_2:    m_tid[2] = val;
      REG_QUOTA_0:      m_quota[0] = val[10:0];
      REG_QUOTA_1:      m_quota[1] = val[10:0];
      REG_QUOTA_2:      m_quota[2] = val[10:0];
      default: ;
    endcase
  endtask

  // apply one request to the model and return the answer it gives
  function automatic answer_t store_apply(logic k, logic [23:0] t, logic [23:0] p,
                                          logic [31:0] n);
    answer_t a;
    int e, slot, best;
    int unsigned lim;
    logic [31:0] el, best_el;
    a = '0;
    e = entry_of(t);
    if (k == KIND_PRODUCE) begin
      lim = (m_limit > CAP) ? CAP : m_limit;
      slot = -1;
      for (int i = 0; i < CAP && slot < 0; i++)
        if (!m_valid[i]) slot = i;
      if (m_occ >= lim || (e >= 0 && m_count[e] >= m_quota[e]) || slot < 0) begin
        a.status = ST_REFUSED;
        return a;
      end
      if (e >= 0) m_count[e] = m_count[e] + 11'd1;
      m_valid[slot] = 1;
      m_type[slot] = t;
      m_prod[slot] = p;
      m_num[slot] = n;
      m_age[slot] = m_stamp;
      m_stamp = m_stamp + 32'd1;
      m_occ++;
      a.status = ST_STORED;
    end else begin
      best = -1;
      best_el = '0;
      for (int i = 0; i < CAP; i++) begin
        if (m_valid[i] && m_type[i] == t) begin
          el = m_stamp - m_age[i];
          if (best < 0 || el > best_el) begin
            best = i;
            best_el = el;
          end
        end
      end
      if (best < 0) begin
        a.status = ST_UNAVAILABLE;
        return a;
      end
      m_valid[best] = 0;
      if (m_occ > 0) m_occ--;
      if (e >= 0 && m_count[e] > 0) m_count[e] = m_count[e] - 11'd1;
      a.status = ST_DELIVERED;
      a.rtype = m_type[best];
      a.rprod = m_prod[best];
      a.rnum = m_num[best];
    end
    return a;
  endfunction

  // ---------------- clock, reset, timeout ----------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    n_cyc = 0;
    forever begin
      @(posedge clk);
      n_cyc++;
      if (n_cyc >= MAX_CYC) begin
        $display("tb_typed_store_with_quotas: done, errors");
        $finish;
      end
    end
  end

  // ---------------- result checking ----------------
  // sampled right after the edge that accepts the result, so nba order is moot
  initial begin
    answer_t want;
    answer_t got;
    n_err = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid) begin
        got = '{status_t'(out_status), out_type, out_producer, out_number};
        if (pending_answers.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("unexpected result %p", got);
        end else begin
          want = pending_answers.pop_front();
          if (got !== want) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  bit no_gaps;

  // start drops only while idling, so back to back requests keep it high
  task automatic idle_burst();
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // one request transfer; typed answer is used when given, else the model's
  task automatic issue(logic k, logic [23:0] t, logic [23:0] p, logic [31:0] n,
                       bit chk, answer_t typed);
    answer_t pred;
    idle_burst();
    start <= 1'b1;
    in_kind <= k;
    in_item_type <= t;
    in_producer_name <= p;
    in_item_number <= n;
    do @(posedge clk); while (busy);
    pred = store_apply(k, t, p, n);
    pending_answers.push_back(chk ? typed : pred);
  endtask

  // config only while idle: wait out every pending answer plus scan time
  task automatic drain();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    store_write(idx, val);
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_type();
    case ($urandom_range(0, 9))
      0, 1, 2: return TY_A;
      3, 4:    return TY_B;
      5, 6:    return TY_C;
      7:       return TY_D;
      8:       return 24'h000000;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic random_phase(int count, int consume_pct);
    logic k;
    for (int i = 0; i < count; i++) begin
      k = ($urandom_range(0, 99) < consume_pct) ? KIND_CONSUME : KIND_PRODUCE;
      issue(k, pick_type(), 24'($urandom()), $urandom(), 0, '0);
    end
  endtask

  // ---------------- main sequence ----------------
  row_t dir_rows[$];

  initial begin
    answer_t a_ref, a_una, a_st;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_PRODUCE;
    in_item_type = '0;
    in_producer_name = '0;
    in_item_number = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_TOTAL_LIMIT;
    cfg_data = '0;
    no_gaps = 0;
    m_limit = TOTAL_LIMIT_RST;
    m_in_use = '0;
    m_occ = 0;
    m_stamp = '0;
    for (int i = 0; i < ENTRY_SLOTS; i++) begin
      m_tid[i] = '0;
      m_quota[i] = '0;
      m_count[i] = '0;
    end
    for (int i = 0; i < CAP; i++) begin
      m_valid[i] = 0;
      m_type[i] = '0;
      m_prod[i] = '0;
      m_num[i] = '0;
      m_age[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    a_ref = '0; a_ref.status = ST_REFUSED;
    a_una = '0; a_una.status = ST_UNAVAILABLE;
    a_st  = '0; a_st.status  = ST_STORED;

    // quotas: A limited to 2, entry 1 and 2 both name B (entry 2 rules, quota 0)
    cfg_write(REG_TYPE_ID_0, TY_A);
    cfg_write(REG_TYPE_ID_1, TY_B);
    cfg_write(REG_TYPE_ID_2, TY_B);
    cfg_write(REG_QUOTA_0, 24'd2);
    cfg_write(REG_QUOTA_1, 24'd1024);
    cfg_write(REG_QUOTA_2, 24'd0);
    cfg_write(REG_TYPES_IN_USE, 24'd3);
    cfg_write(REG_TOTAL_LIMIT, 24'd2047);

    // directed table
    dir_rows = '{
      '{KIND_CONSUME, TY_A,  24'h0,      32'h0,        1, a_una},
      '{KIND_CONSUME, 24'h0, 24'h0,      32'h0,        1, a_una},
      '{KIND_PRODUCE, TY_A,  24'hFFFFFF, 32'hFFFFFFFF, 1, a_st},
      '{KIND_PRODUCE, TY_A,  24'h000000, 32'h00000000, 1, a_st},
      '{KIND_PRODUCE, TY_A,  24'h123456, 32'h1,        1, a_ref},
      '{KIND_PRODUCE, TY_B,  24'h1,      32'h2,        1, a_ref},
      '{KIND_PRODUCE, TY_D,  24'hABCDEF, 32'h80000000, 1, a_st},
      '{KIND_PRODUCE, 24'h0, 24'h555555, 32'h55555555, 1, a_st},
      '{KIND_PRODUCE, TY_D,  24'hAAAAAA, 32'hAAAAAAAA, 1, a_st},
      '{KIND_CONSUME, TY_A,  24'h0,      32'h0,        0, '0},
      '{KIND_PRODUCE, TY_A,  24'h777777, 32'h7,        0, '0},
      '{KIND_CONSUME, TY_D,  24'hFFFFFF, 32'hFFFFFFFF, 0, '0},
      '{KIND_CONSUME, TY_D,  24'h0,      32'h0,        0, '0},
      '{KIND_CONSUME, TY_D,  24'h0,      32'h0,        1, a_una},
      '{KIND_CONSUME, 24'h0, 24'h0,      32'h0,        0, '0},
      '{KIND_CONSUME, TY_A,  24'h0,      32'h0,        0, '0},
      '{KIND_CONSUME, TY_A,  24'h0,      32'h0,        0, '0},
      '{KIND_CONSUME, TY_A,  24'h0,      32'h0,        1, a_una}
    };
    foreach (dir_rows[i])
      issue(dir_rows[i].kind, dir_rows[i].ity, dir_rows[i].prod, dir_rows[i].num,
            dir_rows[i].chk, dir_rows[i].ans);
    drain();

    // total limit zero refuses every produce
    cfg_write(REG_TOTAL_LIMIT, 24'd0);
    issue(KIND_PRODUCE, TY_C, 24'h1, 32'h1, 1, a_ref);
    drain();

    // small limit, tight quotas: lots of refusals and fills
    cfg_write(REG_TOTAL_LIMIT, 24'd6);
    cfg_write(REG_QUOTA_0, 24'd3);
    cfg_write(REG_QUOTA_2, 24'd2);
    random_phase(150, 45);
    drain();

    // lower limit below occupancy, only one entry active, zero quota on A
    cfg_write(REG_TOTAL_LIMIT, 24'd1);
    cfg_write(REG_TYPES_IN_USE, 24'd1);
    cfg_write(REG_QUOTA_0, 24'd0);
    random_phase(60, 50);
    drain();

    // no entries active, moderate limit, producer-heavy then consumer-heavy
    cfg_write(REG_TYPES_IN_USE, 24'd0);
    cfg_write(REG_TOTAL_LIMIT, 24'd24);
    cfg_write(REG_TYPE_ID_1, TY_C);
    random_phase(120, 30);
    random_phase(60, 75);
    drain();

    // two entries, quotas mid range, full limit; last stretch without gaps
    cfg_write(REG_TYPES_IN_USE, 24'd2);
    cfg_write(REG_QUOTA_0, 24'd5);
    cfg_write(REG_QUOTA_1, 24'd4);
    cfg_write(REG_TOTAL_LIMIT, 24'd1024);
    random_phase(100, 45);
    no_gaps = 1;
    random_phase(70, 50);

    // end of run: wait for every answer, then the scan latency
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (n_err == 0) begin
      $display("tb_typed_store_with_quotas: done, clean");
    end else begin
      $display("tb_typed_store_with_quotas: done, errors");
    end
    $finish;
  end

endmodule
